FILE: rtl/core/afv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afv_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned ANGLE_W     = 15;
    localparam int unsigned CRC_W       = 8;
    localparam int unsigned RUN_W       = 8;
    localparam int unsigned TICK_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 56;

    localparam logic [WORD_W-1:0]  CMD_WORD     = 16'h8003;
    localparam logic [CRC_W-1:0]   CRC_INIT     = 8'hFF;
    localparam logic [WORD_W-1:0]  WORD_ZERO    = 16'h0000;
    localparam logic [WORD_W-1:0]  WORD_ONES    = 16'hFFFF;
    localparam logic [WORD_W-1:0]  SAFE_NORST   = 16'h8000;
    localparam logic [WORD_W-1:0]  SAFE_OKS     = 16'h7000;
    localparam logic [RUN_W-1:0]   RUN_MAX      = 8'hFF;

    localparam logic [CRC_W-1:0]   POLY_RESET   = 8'h1D;
    localparam logic [WORD_W-1:0]  MASK_RESET   = 16'h0000;
    localparam logic [RUN_W-1:0]   THRESH_RESET = 8'h08;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_POLY    = 2'd0,
        CFG_FAULT_MASK  = 2'd1,
        CFG_PERSIST_THR = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        OC_GOOD   = 3'd0,
        OC_NORESP = 3'd1,
        OC_CRC    = 3'd2,
        OC_RESET  = 3'd3,
        OC_STATUS = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        HK_NONE      = 2'd0,
        HK_SYNC      = 2'd1,
        HK_MAGNITUDE = 2'd2,
        HK_RELOCK    = 2'd3
    } hk_action_t;

endpackage

`default_nettype wire

FILE: rtl/core/afv_crc.sv
`timescale 1ns / 1ps
`default_nettype none

module afv_crc (
    input  wire logic [afv_pkg::CRC_W-1:0]  poly,
    input  wire logic [afv_pkg::WORD_W-1:0] status_word,
    input  wire logic [afv_pkg::WORD_W-1:0] aux_status_word,
    input  wire logic [afv_pkg::WORD_W-1:0] angle_word,
    output logic      [afv_pkg::CRC_W-1:0]  crc
);
    import afv_pkg::*;

    localparam int unsigned NBYTES = 8;

    logic [NBYTES*CRC_W-1:0] stream;
    logic [CRC_W-1:0]        acc;

    assign stream = {CMD_WORD, status_word, aux_status_word, angle_word};

    always_comb
    begin
        acc = CRC_INIT;
        for (int b = NBYTES - 1; b >= 0; b--)
        begin
            acc = acc ^ stream[b*CRC_W +: CRC_W];
            for (int i = 0; i < CRC_W; i++)
            begin
                if (acc[CRC_W-1])
                begin
                    acc = {acc[CRC_W-2:0], 1'b0} ^ poly;
                end
                else
                begin
                    acc = {acc[CRC_W-2:0], 1'b0};
                end
            end
        end
        crc = ~acc;
    end

endmodule

`default_nettype wire

FILE: rtl/core/angle_frame_validator.sv
//  channel  dir  bits  fields, lowest bit up
//  s_axis   in   72    status_word[15:0] aux_status_word[31:16] angle_word[47:32]
//                      safety_word[63:48] config_failed[64]
//  m_axis   out  56    outcome angle_raw angle_updated stale degraded no_valid_angle
//                      fail_run sequence_res housekeeping_action relock_now
//  cfg      in   16    write enable, 2-bit register index, write data
//
//  One frame per cycle sustained while m_axis_tready is high; a request passes the input
//  register, then the CRC and classification logic into the result register.
//  Reset clears control state and the frame state; the angle starts as not valid.
//  A stalled result holds in the result register while the input register takes the
//  next request; the input side stalls only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module angle_frame_validator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // status_word, aux_status_word, angle_word, safety_word, config_failed, zero pad
    input  wire logic [afv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // outcome, angle_raw, angle_updated, stale, degraded, no_valid_angle,
    // fail_run, sequence_res, housekeeping_action, relock_now, zero pad
    output logic      [afv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [afv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [afv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import afv_pkg::*;

    logic [CRC_W-1:0]   poly_reg;
    logic [WORD_W-1:0]  mask_reg;
    logic [RUN_W-1:0]   thresh_reg;

    logic               in_valid_reg;
    logic [WORD_W-1:0]  st_reg, ax_reg, an_reg, sf_reg;
    logic               cfg_fail_reg;

    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [WORD_W-1:0]  count_reg, count_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               stale_reg, stale_next;
    logic               degr_reg, degr_next;
    logic               inval_reg, inval_next;

    logic               out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic               advance;
    logic [CRC_W-1:0]   crc;
    outcome_t           oc;
    hk_action_t         hk;
    logic               upd;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= POLY_RESET;
            mask_reg   <= MASK_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CRC_POLY:    poly_reg   <= cfg_data[CRC_W-1:0];
                CFG_FAULT_MASK:  mask_reg   <= cfg_data;
                CFG_PERSIST_THR: thresh_reg <= cfg_data[RUN_W-1:0];
                default:         ;
            endcase
        end
    end

    afv_crc u_crc (
        .poly            (poly_reg),
        .status_word     (st_reg),
        .aux_status_word (ax_reg),
        .angle_word      (an_reg),
        .crc             (crc)
    );

    always_comb
    begin
        if ((st_reg == WORD_ZERO && ax_reg == WORD_ZERO &&
             an_reg == WORD_ZERO && sf_reg == WORD_ZERO) ||
            (st_reg == WORD_ONES && ax_reg == WORD_ONES &&
             an_reg == WORD_ONES && sf_reg == WORD_ONES))
        begin
            oc = OC_NORESP;
        end
        else if (sf_reg[CRC_W-1:0] != crc)
        begin
            oc = OC_CRC;
        end
        else if ((sf_reg & SAFE_NORST) == WORD_ZERO)
        begin
            oc = OC_RESET;
        end
        else if ((sf_reg & SAFE_OKS) != SAFE_OKS || (st_reg & mask_reg) != WORD_ZERO)
        begin
            oc = OC_STATUS;
        end
        else
        begin
            oc = OC_GOOD;
        end

        count_next = count_reg + 1'b1;
        tick_next  = tick_reg + 1'b1;
        angle_next = angle_reg;
        stale_next = stale_reg;
        degr_next  = degr_reg;
        inval_next = inval_reg;
        upd        = 1'b0;

        if (oc == OC_GOOD)
        begin
            run_next   = '0;
            angle_next = an_reg[ANGLE_W-1:0];
            upd        = 1'b1;
            stale_next = 1'b0;
            degr_next  = 1'b0;
            inval_next = 1'b0;
        end
        else
        begin
            run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
            if (oc == OC_STATUS && run_next >= thresh_reg)
            begin
                angle_next = an_reg[ANGLE_W-1:0];
                upd        = 1'b1;
                degr_next  = 1'b1;
                stale_next = 1'b0;
                inval_next = 1'b0;
            end
            else
            begin
                stale_next = 1'b1;
            end
        end

        if (tick_next[3:0] == 4'd0)
        begin
            if (cfg_fail_reg)
            begin
                hk = HK_RELOCK;
            end
            else
            begin
                hk = tick_next[4] ? HK_MAGNITUDE : HK_SYNC;
            end
        end
        else
        begin
            hk = HK_NONE;
        end

        out_data_next = {7'd0, (oc == OC_RESET), hk, count_next, run_next,
                         inval_next, degr_next, stale_next, upd, angle_next, oc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            run_reg       <= '0;
            count_reg     <= '0;
            tick_reg      <= '0;
            stale_reg     <= 1'b0;
            degr_reg      <= 1'b0;
            inval_reg     <= 1'b1;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                angle_reg     <= angle_next;
                run_reg       <= run_next;
                count_reg     <= count_next;
                tick_reg      <= tick_next;
                stale_reg     <= stale_next;
                degr_reg      <= degr_next;
                inval_reg     <= inval_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload until the next request or result moves
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            st_reg       <= s_axis_tdata[15:0];
            ax_reg       <= s_axis_tdata[31:16];
            an_reg       <= s_axis_tdata[47:32];
            sf_reg       <= s_axis_tdata[63:48];
            cfg_fail_reg <= s_axis_tdata[64];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
